### design/mse_pkg.sv
// ----------------------------------------------------------------------------
// mse_pkg
// Shared types, opcodes and constants of the MIPS subset execute core.
// ----------------------------------------------------------------------------
package mse_pkg;

	localparam int unsigned XLEN           = 32;
	localparam int unsigned RIDX_W         = 5;
	localparam int unsigned NREGS          = 32;
	localparam int unsigned LEN_W          = 21;
	localparam int unsigned CFG_IDX_W      = 1;
	localparam int unsigned DATA_WORDS_DEF = 1024;

	localparam logic [XLEN-1:0]  TEXT_BASE_RST = 32'h0040_0000;
	localparam logic [LEN_W-1:0] TEXT_LEN_RST  = 21'd1024;

	localparam logic [CFG_IDX_W-1:0] CFG_TEXT_BASE   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TEXT_LENGTH = 1'd1;

	localparam logic [5:0] OP_RTYPE = 6'h00;
	localparam logic [5:0] OP_J     = 6'h02;
	localparam logic [5:0] OP_JAL   = 6'h03;
	localparam logic [5:0] OP_BEQ   = 6'h04;
	localparam logic [5:0] OP_BNE   = 6'h05;
	localparam logic [5:0] OP_ADDIU = 6'h09;
	localparam logic [5:0] OP_SLTIU = 6'h0b;
	localparam logic [5:0] OP_ANDI  = 6'h0c;
	localparam logic [5:0] OP_ORI   = 6'h0d;
	localparam logic [5:0] OP_LUI   = 6'h0f;
	localparam logic [5:0] OP_LW    = 6'h23;
	localparam logic [5:0] OP_SW    = 6'h2b;

	localparam logic [5:0] FN_SLL  = 6'h00;
	localparam logic [5:0] FN_SRL  = 6'h02;
	localparam logic [5:0] FN_JR   = 6'h08;
	localparam logic [5:0] FN_ADD  = 6'h20;
	localparam logic [5:0] FN_ADDU = 6'h21;
	localparam logic [5:0] FN_SUBU = 6'h23;
	localparam logic [5:0] FN_AND  = 6'h24;
	localparam logic [5:0] FN_OR   = 6'h25;
	localparam logic [5:0] FN_NOR  = 6'h27;
	localparam logic [5:0] FN_SLTU = 6'h2b;

	localparam logic [RIDX_W-1:0] LINK_REG = 5'd31;

	typedef struct packed {
		logic [5:0]  opcode;
		logic [5:0]  func_field;
		logic [4:0]  src_reg;
		logic [4:0]  tgt_reg;
		logic [4:0]  dst_reg;
		logic [4:0]  shift_amount;
		logic [15:0] immediate;
		logic [25:0] jump_target;
	} inst_t;

	typedef struct packed {
		logic [31:0] next_pc;
		logic        reg_write;
		logic [4:0]  written_index;
		logic [31:0] written_value;
		logic        store_done;
		logic [31:0] store_address;
		logic [31:0] store_data;
		logic        halted;
		logic        bad_opcode;
	} res_t;

	typedef struct packed {
		res_t        res;
		logic        is_load;
		logic        is_store;
		logic [31:0] mem_addr;
	} exec_t;

	typedef enum logic [4:0] {
		MP_IDLE = 5'b00001,
		MP_MUL  = 5'b00010,
		MP_QD   = 5'b00100,
		MP_ACC  = 5'b01000,
		MP_LOAD = 5'b10000
	} mphase_t;

endpackage

### design/mse_regfile.sv
// ----------------------------------------------------------------------------
// mse_regfile
// 32 x 32 register file: one write port, two registered read ports, valid
// bits for reset-to-zero and a bypass of the write taken at the last edge.
// ----------------------------------------------------------------------------
module mse_regfile (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [mse_pkg::RIDX_W-1:0] ra,
	input  logic [mse_pkg::RIDX_W-1:0] rb,
	input  logic                       we,
	input  logic [mse_pkg::RIDX_W-1:0] widx,
	input  logic [mse_pkg::XLEN-1:0]   wdata,
	output logic [mse_pkg::XLEN-1:0]   rdata_a,
	output logic [mse_pkg::XLEN-1:0]   rdata_b
);
	import mse_pkg::*;

	logic [XLEN-1:0]   mem [NREGS];
	logic [NREGS-1:0]  vld_q;
	logic [RIDX_W-1:0] ra_q;
	logic [RIDX_W-1:0] rb_q;
	logic [XLEN-1:0]   da_q;
	logic [XLEN-1:0]   db_q;
	logic              va_q;
	logic              vb_q;
	logic              byp_vld_q;
	logic [RIDX_W-1:0] byp_idx_q;
	logic [XLEN-1:0]   byp_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[widx] <= wdata;
		end
		da_q       <= mem[ra];
		db_q       <= mem[rb];
		ra_q       <= ra;
		rb_q       <= rb;
		byp_idx_q  <= widx;
		byp_data_q <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			va_q      <= 1'b0;
			vb_q      <= 1'b0;
			byp_vld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[widx] <= 1'b1;
			end
			va_q      <= vld_q[ra];
			vb_q      <= vld_q[rb];
			byp_vld_q <= we;
		end
	end

	assign rdata_a = (byp_vld_q && byp_idx_q == ra_q) ? byp_data_q :
		(va_q ? da_q : '0);
	assign rdata_b = (byp_vld_q && byp_idx_q == rb_q) ? byp_data_q :
		(vb_q ? db_q : '0);

endmodule

### design/mse_index.sv
// ----------------------------------------------------------------------------
// mse_index
// Word address modulo DATA_WORDS: a part-select for a power of two, else a
// reciprocal multiply, a back-multiply and one correcting subtract.
// ----------------------------------------------------------------------------
module mse_index #(
	parameter int unsigned DATA_WORDS = mse_pkg::DATA_WORDS_DEF
) (
	input  logic                          clk,
	input  logic                          mul_en,
	input  logic                          qd_en,
	input  logic [29:0]                   word,
	output logic [$clog2(DATA_WORDS)-1:0] idx
);
	import mse_pkg::*;

	localparam int unsigned IDX_W = $clog2(DATA_WORDS);

	if ((DATA_WORDS & (DATA_WORDS - 1)) == 0) begin : g_pow2
		assign idx = word[IDX_W-1:0];
	end else begin : g_recip
		localparam int unsigned K  = 30 + IDX_W;
		localparam int unsigned QW = 31 - IDX_W;
		localparam logic [30:0] RECIP = 31'((64'd1 << K) / 64'(DATA_WORDS));
		localparam logic [IDX_W:0] DIVW = (IDX_W+1)'(DATA_WORDS);

		logic [60:0]           prod_q;
		logic [QW+IDX_W-1:0]   qd_full;
		logic [29:0]           qd_q;
		logic [IDX_W:0]        rem;

		always_ff @(posedge clk) begin
			if (mul_en) begin
				prod_q <= 61'(word) * 61'(RECIP);
			end
			if (qd_en) begin
				qd_q <= qd_full[29:0];
			end
		end

		assign qd_full = (QW+IDX_W)'(prod_q[60:K]) * (QW+IDX_W)'(DATA_WORDS);
		assign rem     = (IDX_W+1)'(word - qd_q);
		assign idx     = (rem >= DIVW) ? IDX_W'(rem - DIVW) : rem[IDX_W-1:0];
	end

endmodule

### design/mse_dmem.sv
// ----------------------------------------------------------------------------
// mse_dmem
// Data memory: one write port, one registered read port, and a clearing
// sweep of one word per cycle after reset.
// ----------------------------------------------------------------------------
module mse_dmem #(
	parameter int unsigned DATA_WORDS = mse_pkg::DATA_WORDS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          we,
	input  logic                          re,
	input  logic [$clog2(DATA_WORDS)-1:0] idx,
	input  logic [mse_pkg::XLEN-1:0]      wdata,
	output logic [mse_pkg::XLEN-1:0]      rdata,
	output logic                          clearing
);
	import mse_pkg::*;

	localparam int unsigned IDX_W = $clog2(DATA_WORDS);
	localparam logic [IDX_W-1:0] LAST = IDX_W'(DATA_WORDS - 1);

	logic [XLEN-1:0]  mem [DATA_WORDS];
	logic [XLEN-1:0]  rdata_q;
	logic             clr_q;
	logic [IDX_W-1:0] clr_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == LAST) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[clr_cnt_q] <= '0;
		end else if (we) begin
			mem[idx] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[idx];
		end
	end

	assign rdata    = rdata_q;
	assign clearing = clr_q;

endmodule

### design/mse_exec.sv
// ----------------------------------------------------------------------------
// mse_exec
// Execute logic: decode, ALU, branch and jump targets, write-back and store
// selection for one instruction.
// ----------------------------------------------------------------------------
module mse_exec (
	input  mse_pkg::inst_t           inst,
	input  logic [mse_pkg::XLEN-1:0] a,
	input  logic [mse_pkg::XLEN-1:0] b,
	input  logic [mse_pkg::XLEN-1:0] pc,
	input  logic [mse_pkg::XLEN-1:0] ld_data,
	output mse_pkg::exec_t           exe
);
	import mse_pkg::*;

	logic [XLEN-1:0]   simm;
	logic [XLEN-1:0]   zimm;
	logic [XLEN-1:0]   pc4;
	logic [XLEN-1:0]   br_tgt;
	logic [XLEN-1:0]   j_tgt;
	logic [XLEN-1:0]   sum;
	logic              wr;
	logic [RIDX_W-1:0] widx;
	logic [XLEN-1:0]   wval;

	assign simm   = {{16{inst.immediate[15]}}, inst.immediate};
	assign zimm   = {16'h0000, inst.immediate};
	assign pc4    = pc + 32'd4;
	assign br_tgt = pc4 + {simm[29:0], 2'b00};
	assign j_tgt  = {pc4[31:28], inst.jump_target, 2'b00};
	assign sum    = a + simm;

	always_comb begin
		exe          = '0;
		exe.mem_addr = sum;
		exe.res.next_pc = pc4;
		wr   = 1'b0;
		widx = '0;
		wval = '0;
		case (inst.opcode)
			OP_ADDIU: begin
				wr = 1'b1; widx = inst.tgt_reg; wval = sum;
			end
			OP_ANDI: begin
				wr = 1'b1; widx = inst.tgt_reg; wval = a & zimm;
			end
			OP_LUI: begin
				wr = 1'b1; widx = inst.tgt_reg; wval = {inst.immediate, 16'h0000};
			end
			OP_ORI: begin
				wr = 1'b1; widx = inst.tgt_reg; wval = a | zimm;
			end
			OP_SLTIU: begin
				wr = 1'b1; widx = inst.tgt_reg; wval = {31'd0, a < simm};
			end
			OP_LW: begin
				wr = 1'b1; widx = inst.tgt_reg; wval = ld_data;
				exe.is_load = 1'b1;
			end
			OP_SW: begin
				exe.is_store          = 1'b1;
				exe.res.store_done    = 1'b1;
				exe.res.store_address = sum;
				exe.res.store_data    = b;
			end
			OP_BEQ: begin
				if (a == b) begin
					exe.res.next_pc = br_tgt;
				end
			end
			OP_BNE: begin
				if (a != b) begin
					exe.res.next_pc = br_tgt;
				end
			end
			OP_J: begin
				exe.res.next_pc = j_tgt;
			end
			OP_JAL: begin
				wr = 1'b1; widx = LINK_REG; wval = pc + 32'd8;
				exe.res.next_pc = j_tgt;
			end
			OP_RTYPE: begin
				case (inst.func_field)
					FN_SLL: begin
						wr = 1'b1; widx = inst.dst_reg; wval = b << inst.shift_amount;
					end
					FN_SRL: begin
						wr = 1'b1; widx = inst.dst_reg; wval = b >> inst.shift_amount;
					end
					FN_JR: begin
						exe.res.next_pc = a;
					end
					FN_ADD, FN_ADDU: begin
						wr = 1'b1; widx = inst.dst_reg; wval = a + b;
					end
					FN_SUBU: begin
						wr = 1'b1; widx = inst.dst_reg; wval = a - b;
					end
					FN_AND: begin
						wr = 1'b1; widx = inst.dst_reg; wval = a & b;
					end
					FN_OR: begin
						wr = 1'b1; widx = inst.dst_reg; wval = a | b;
					end
					FN_NOR: begin
						wr = 1'b1; widx = inst.dst_reg; wval = ~(a | b);
					end
					FN_SLTU: begin
						wr = 1'b1; widx = inst.dst_reg; wval = {31'd0, a < b};
					end
					default: begin
						exe.res.bad_opcode = 1'b1;
					end
				endcase
			end
			default: begin
				exe.res.bad_opcode = 1'b1;
			end
		endcase
		// drop writes to register zero
		if (wr && widx != '0) begin
			exe.res.reg_write     = 1'b1;
			exe.res.written_index = widx;
			exe.res.written_value = wval;
		end
	end

endmodule

### design/mips_subset_execute_core.sv
// ----------------------------------------------------------------------------
// mips_subset_execute_core
// Single-pass MIPS subset execute core: register file, PC, data memory.
// ----------------------------------------------------------------------------
// Each accepted word is one pre-decoded instruction; each yields one result
// word. ALU, branch and jump instructions issue back to back while results
// are taken; the register file read is steered from the accepted word,
// and a one-entry bypass covers the write of the previous instruction.
// Memory instructions go through the data memory's registered read port:
// SW passes the states IDLE and ACC, and LW IDLE, ACC and LOAD, when
// DATA_WORDS is a power of two; otherwise MUL and QD come after IDLE, as
// the word address is reduced modulo DATA_WORDS by a reciprocal multiply
// and a back-multiply. After reset the data memory is cleared one word
// per cycle, with inst_ready low; configuration writes are taken
// throughout. A write of text_base also reloads the PC.
module mips_subset_execute_core #(
	parameter int unsigned DATA_WORDS = mse_pkg::DATA_WORDS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            inst_valid,
	output logic                            inst_ready,
	input  mse_pkg::inst_t                  inst,
	output logic                            res_valid,
	input  logic                            res_ready,
	output mse_pkg::res_t                   res,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [mse_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mse_pkg::XLEN-1:0]        cfg_data
);
	import mse_pkg::*;

	localparam int unsigned IDX_W   = $clog2(DATA_WORDS);
	localparam bit          DW_POW2 = (DATA_WORDS & (DATA_WORDS - 1)) == 0;

	inst_t             inst_s1;
	logic              vld_s1;
	res_t              res_s2;
	logic              vld_s2;
	logic [XLEN-1:0]   pc_q;
	logic [XLEN-1:0]   base_q;
	logic [LEN_W-1:0]  len_q;
	logic              stopped_q;
	mphase_t           phase_q;
	logic [XLEN-1:0]   addr_q;

	logic              acc;
	logic              out_free;
	logic              fire;
	logic              halt_now;
	logic [XLEN-1:0]   pc_off;
	logic [RIDX_W-1:0] ra;
	logic [XLEN-1:0]   op_a;
	logic [XLEN-1:0]   op_b;
	logic [XLEN-1:0]   ld_data;
	logic              clearing;
	logic              rf_we;
	logic              dm_we;
	logic              dm_re;
	logic [IDX_W-1:0]  dm_idx;
	exec_t             exe;
	res_t              fin;

	assign pc_off   = pc_q - base_q;
	assign halt_now = stopped_q || (pc_off[31:2] >= 30'(len_q));
	assign out_free = !vld_s2 || res_ready;
	assign fire     = vld_s1 && out_free &&
		((phase_q == MP_IDLE && (halt_now || !(exe.is_load || exe.is_store))) ||
		 (phase_q == MP_ACC && exe.is_store) || phase_q == MP_LOAD);
	assign inst_ready = !clearing && (!vld_s1 || fire);
	assign acc        = inst_valid && inst_ready;
	assign cfg_ready  = 1'b1;
	assign ra         = acc ? inst.src_reg : inst_s1.src_reg;

	assign rf_we = fire && !halt_now && exe.res.reg_write;
	assign dm_we = fire && phase_q == MP_ACC;
	assign dm_re = vld_s1 && phase_q == MP_ACC && exe.is_load;

	mse_regfile u_rf (
		.clk     (clk),
		.arst_n  (arst_n),
		.ra      (ra),
		.rb      (acc ? inst.tgt_reg : inst_s1.tgt_reg),
		.we      (rf_we),
		.widx    (exe.res.written_index),
		.wdata   (exe.res.written_value),
		.rdata_a (op_a),
		.rdata_b (op_b)
	);

	mse_exec u_exec (
		.inst    (inst_s1),
		.a       (op_a),
		.b       (op_b),
		.pc      (pc_q),
		.ld_data (ld_data),
		.exe     (exe)
	);

	mse_index #(.DATA_WORDS(DATA_WORDS)) u_idx (
		.clk    (clk),
		.mul_en (phase_q == MP_MUL),
		.qd_en  (phase_q == MP_QD),
		.word   (addr_q[31:2]),
		.idx    (dm_idx)
	);

	mse_dmem #(.DATA_WORDS(DATA_WORDS)) u_dmem (
		.clk      (clk),
		.arst_n   (arst_n),
		.we       (dm_we),
		.re       (dm_re),
		.idx      (dm_idx),
		.wdata    (op_b),
		.rdata    (ld_data),
		.clearing (clearing)
	);

	always_comb begin
		if (halt_now) begin
			fin         = '0;
			fin.next_pc = pc_q;
			fin.halted  = 1'b1;
		end else begin
			fin = exe.res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			pc_q      <= TEXT_BASE_RST;
			base_q    <= TEXT_BASE_RST;
			len_q     <= TEXT_LEN_RST;
			stopped_q <= 1'b0;
			phase_q   <= MP_IDLE;
		end else begin
			if (acc) begin
				vld_s1 <= 1'b1;
			end else if (fire) begin
				vld_s1 <= 1'b0;
			end
			if (fire) begin
				vld_s2 <= 1'b1;
			end else if (res_ready) begin
				vld_s2 <= 1'b0;
			end
			if (fire) begin
				stopped_q <= stopped_q | halt_now;
			end
			if (cfg_valid && cfg_index == CFG_TEXT_BASE) begin
				base_q <= cfg_data;
				pc_q   <= cfg_data;
			end else if (fire) begin
				pc_q <= fin.next_pc;
			end
			if (cfg_valid && cfg_index == CFG_TEXT_LENGTH) begin
				len_q <= cfg_data[LEN_W-1:0];
			end
			case (phase_q)
				MP_IDLE: begin
					if (vld_s1 && !halt_now && (exe.is_load || exe.is_store)) begin
						phase_q <= DW_POW2 ? MP_ACC : MP_MUL;
					end
				end
				MP_MUL:  phase_q <= MP_QD;
				MP_QD:   phase_q <= MP_ACC;
				MP_ACC: begin
					if (exe.is_load) begin
						phase_q <= MP_LOAD;
					end else if (fire) begin
						phase_q <= MP_IDLE;
					end
				end
				MP_LOAD: begin
					if (fire) begin
						phase_q <= MP_IDLE;
					end
				end
				default: phase_q <= MP_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			inst_s1 <= inst;
		end
		if (fire) begin
			res_s2 <= fin;
		end
		if (phase_q == MP_IDLE) begin
			addr_q <= exe.mem_addr;
		end
	end

	assign res_valid = vld_s2;
	assign res       = res_s2;

	a_phase_holds_word: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != MP_IDLE |-> vld_s1)
		else $error("memory phase active without an instruction");

	a_no_issue_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !vld_s1 && !inst_ready)
		else $error("instruction held during memory clear");

	a_halt_holds_pc: assert property (@(posedge clk) disable iff (!arst_n)
		fire && halt_now && !cfg_valid |=> pc_q == $past(pc_q) && stopped_q)
		else $error("halted instruction moved the pc");

	a_halt_clean: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && res_s2.halted |->
		!res_s2.reg_write && !res_s2.store_done && !res_s2.bad_opcode)
		else $error("halted result carries side effects");

	a_no_r0_write: assert property (@(posedge clk) disable iff (!arst_n)
		rf_we |-> exe.res.written_index != '0)
		else $error("write to register zero");

endmodule
